/* sv/md5bc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 block compression package
// Shared widths, register indexes, queue entry and status types, the sine
// constant table, the rotate table and the MD5 step functions.
// ----------------------------------------------------------------------------
package md5bc_pkg;

    localparam int WORD_W      = 32;
    localparam int IDX_W       = 4;
    localparam int STEP_W      = 6;
    localparam int CFG_INDEX_W = 8;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [STEP_W-1:0] LAST_STEP = 6'd63;
    localparam logic [IDX_W-1:0]  LAST_WORD = 4'd15;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_INIT_A = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INIT_B = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_INIT_C = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_INIT_D = 8'd3;

    // Standard MD5 initial chaining words.
    localparam logic [WORD_W-1:0] IV_A = 32'h67452301;
    localparam logic [WORD_W-1:0] IV_B = 32'hefcdab89;
    localparam logic [WORD_W-1:0] IV_C = 32'h98badcfe;
    localparam logic [WORD_W-1:0] IV_D = 32'h10325476;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              start;
        logic [IDX_W-1:0]  index;
        logic              last;
    } md5bc_entry_t;

    typedef enum logic [1:0] {
        BACK_COLLECT,
        BACK_LOAD,
        BACK_STEP,
        BACK_FINISH
    } md5bc_back_state_t;

    typedef struct packed {
        md5bc_back_state_t state;
        logic [STEP_W-1:0] step;
    } md5bc_status_t;

    localparam logic [WORD_W-1:0] SINE_TAB [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROT_TAB [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    // Message word used by a step; all arithmetic is modulo sixteen.
    function automatic logic [IDX_W-1:0] msg_index(input logic [STEP_W-1:0] step);
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] res;
        lo = step[IDX_W-1:0];
        unique case (step[5:4])
            2'd0:    res = lo;
            2'd1:    res = lo * 4'd5 + 4'd1;
            2'd2:    res = lo * 4'd3 + 4'd5;
            default: res = lo * 4'd7;
        endcase
        return res;
    endfunction

    function automatic logic [WORD_W-1:0] round_fn(input logic [1:0] rnd,
                                                   input logic [WORD_W-1:0] b,
                                                   input logic [WORD_W-1:0] c,
                                                   input logic [WORD_W-1:0] d);
        logic [WORD_W-1:0] res;
        unique case (rnd)
            2'd0:    res = (b & c) | (~b & d);
            2'd1:    res = (b & d) | (c & ~d);
            2'd2:    res = b ^ c ^ d;
            default: res = c ^ (b | ~d);
        endcase
        return res;
    endfunction

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                               input logic [4:0] s);
        logic [2*WORD_W-1:0] wide;
        wide = {x, x} << s;
        return wide[2*WORD_W-1:WORD_W];
    endfunction

endpackage

/* sv/md5bc_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 message word channel
// Valid/ready channel carrying one message word and its start flag.
// ----------------------------------------------------------------------------
interface md5bc_in_if;
    import md5bc_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] message_word;
    logic              start_message;

    modport source (output valid, output message_word, output start_message, input ready);
    modport sink   (input valid, input message_word, input start_message, output ready);
endinterface

/* sv/md5bc_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 digest channel
// Valid/ready channel carrying the four updated chaining words.
// ----------------------------------------------------------------------------
interface md5bc_out_if;
    import md5bc_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] digest_a;
    logic [WORD_W-1:0] digest_b;
    logic [WORD_W-1:0] digest_c;
    logic [WORD_W-1:0] digest_d;

    modport source (output valid, output digest_a, output digest_b, output digest_c,
                    output digest_d, input ready);
    modport sink   (input valid, input digest_a, input digest_b, input digest_c,
                    input digest_d, output ready);
endinterface

/* sv/md5bc_cfg_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 configuration write channel
// Valid/ready channel carrying a register index and its write data.
// ----------------------------------------------------------------------------
interface md5bc_cfg_if;
    import md5bc_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [WORD_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/md5bc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 front end
// Accepts message words, tracks the word position within the block and
// tags each word with its slot, a start mark and a block-complete mark.
// ----------------------------------------------------------------------------
module md5bc_front (
    input  logic                    clk,
    input  logic                    rst_n,
    md5bc_in_if.sink                msg,
    output logic                    push_valid,
    input  logic                    push_ready,
    output md5bc_pkg::md5bc_entry_t push_entry
);
    import md5bc_pkg::*;

    logic [IDX_W-1:0] word_cnt_reg;
    logic [IDX_W-1:0] word_cnt_next;
    logic [IDX_W-1:0] slot;

    // A start flag discards any partial block, so the word lands in slot zero.
    assign slot = msg.start_message ? '0 : word_cnt_reg;

    assign msg.ready          = push_ready;
    assign push_valid         = msg.valid;
    assign push_entry.word    = msg.message_word;
    assign push_entry.start   = msg.start_message;
    assign push_entry.index   = slot;
    assign push_entry.last    = (slot == LAST_WORD);
    assign word_cnt_next      = slot + 4'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_cnt_reg <= '0;
        end
        else if (msg.valid && push_ready)
        begin
            word_cnt_reg <= word_cnt_next;
        end
    end
endmodule

/* sv/md5bc_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 word queue
// Small first-in first-out buffer between the front end and the round engine.
// ----------------------------------------------------------------------------
module md5bc_queue #(
    parameter int DEPTH = md5bc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push_valid,
    output logic                    push_ready,
    input  md5bc_pkg::md5bc_entry_t push_entry,
    output logic                    pop_valid,
    input  logic                    pop_ready,
    output md5bc_pkg::md5bc_entry_t pop_entry
);
    import md5bc_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    md5bc_entry_t     slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule

/* sv/md5bc_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 round engine
// Stores block words, holds the configuration and chaining words, runs the
// 64 steps one per cycle and presents the updated chaining value.
// ----------------------------------------------------------------------------
module md5bc_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     pop_valid,
    output logic                     pop_ready,
    input  md5bc_pkg::md5bc_entry_t  pop_entry,
    md5bc_cfg_if.sink                cfg,
    md5bc_out_if.source              digest,
    output md5bc_pkg::md5bc_status_t status
);
    import md5bc_pkg::*;

    md5bc_back_state_t state_reg;
    md5bc_back_state_t state_next;

    logic [WORD_W-1:0] init_a_reg, init_b_reg, init_c_reg, init_d_reg;
    logic [WORD_W-1:0] cv_a_reg, cv_b_reg, cv_c_reg, cv_d_reg;
    logic [WORD_W-1:0] wa_reg, wb_reg, wc_reg, wd_reg;
    logic [WORD_W-1:0] pre_reg;
    logic [WORD_W-1:0] block_words_reg [16];
    logic [STEP_W-1:0] step_reg;
    logic              out_valid_reg;
    logic [WORD_W-1:0] out_a_reg, out_b_reg, out_c_reg, out_d_reg;

    logic              pop_fire;
    logic              load_out;
    logic [STEP_W-1:0] pre_step;
    logic [WORD_W-1:0] pre_a;
    logic [WORD_W-1:0] pre_next;
    logic [WORD_W-1:0] mix;
    logic [WORD_W-1:0] new_b;
    logic [WORD_W-1:0] sum_a, sum_b, sum_c, sum_d;

    assign pop_fire = pop_valid && pop_ready;
    assign cfg.ready = 1'b1;

    // The addend a + K + M of the next step is prepared and registered ahead of
    // that step; the next step's a is the current d.
    assign pre_step = (state_reg == BACK_LOAD) ? '0 : step_reg + 6'd1;
    assign pre_a    = (state_reg == BACK_LOAD) ? cv_a_reg : wd_reg;
    assign pre_next = pre_a + SINE_TAB[pre_step] + block_words_reg[msg_index(pre_step)];

    assign mix   = round_fn(step_reg[5:4], wb_reg, wc_reg, wd_reg) + pre_reg;
    assign new_b = wb_reg + rotl(mix, ROT_TAB[{step_reg[5:4], step_reg[1:0]}]);

    assign sum_a = cv_a_reg + wa_reg;
    assign sum_b = cv_b_reg + wb_reg;
    assign sum_c = cv_c_reg + wc_reg;
    assign sum_d = cv_d_reg + wd_reg;

    assign digest.valid    = out_valid_reg;
    assign digest.digest_a = out_a_reg;
    assign digest.digest_b = out_b_reg;
    assign digest.digest_c = out_c_reg;
    assign digest.digest_d = out_d_reg;

    assign status.state = state_reg;
    assign status.step  = step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BACK_COLLECT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pop_ready  = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            BACK_COLLECT:
            begin
                pop_ready = 1'b1;
                if (pop_valid && pop_entry.last)
                begin
                    state_next = BACK_LOAD;
                end
            end
            BACK_LOAD:
            begin
                state_next = BACK_STEP;
            end
            BACK_STEP:
            begin
                if (step_reg == LAST_STEP)
                begin
                    state_next = BACK_FINISH;
                end
            end
            BACK_FINISH:
            begin
                if (!out_valid_reg || digest.ready)
                begin
                    load_out   = 1'b1;
                    state_next = BACK_COLLECT;
                end
            end
            default:
            begin
                state_next = BACK_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop_fire)
        begin
            block_words_reg[pop_entry.index] <= pop_entry.word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_a_reg    <= IV_A;
            init_b_reg    <= IV_B;
            init_c_reg    <= IV_C;
            init_d_reg    <= IV_D;
            cv_a_reg      <= IV_A;
            cv_b_reg      <= IV_B;
            cv_c_reg      <= IV_C;
            cv_d_reg      <= IV_D;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    CFG_INIT_A: init_a_reg <= cfg.data;
                    CFG_INIT_B: init_b_reg <= cfg.data;
                    CFG_INIT_C: init_c_reg <= cfg.data;
                    CFG_INIT_D: init_d_reg <= cfg.data;
                    default:    ;
                endcase
            end

            if (pop_fire && pop_entry.start)
            begin
                cv_a_reg <= init_a_reg;
                cv_b_reg <= init_b_reg;
                cv_c_reg <= init_c_reg;
                cv_d_reg <= init_d_reg;
            end
            else if (load_out)
            begin
                cv_a_reg <= sum_a;
                cv_b_reg <= sum_b;
                cv_c_reg <= sum_c;
                cv_d_reg <= sum_d;
            end

            if (state_reg == BACK_LOAD)
            begin
                step_reg <= '0;
            end
            else if (state_reg == BACK_STEP)
            begin
                step_reg <= step_reg + 6'd1;
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (digest.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == BACK_LOAD)
        begin
            wa_reg  <= cv_a_reg;
            wb_reg  <= cv_b_reg;
            wc_reg  <= cv_c_reg;
            wd_reg  <= cv_d_reg;
            pre_reg <= pre_next;
        end
        else if (state_reg == BACK_STEP)
        begin
            wa_reg  <= wd_reg;
            wb_reg  <= new_b;
            wc_reg  <= wb_reg;
            wd_reg  <= wc_reg;
            pre_reg <= pre_next;
        end
        if (load_out)
        begin
            out_a_reg <= sum_a;
            out_b_reg <= sum_b;
            out_c_reg <= sum_c;
            out_d_reg <= sum_d;
        end
    end
endmodule

/* sv/md5_block_compression_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 block compression top level
// Buffers a padded message sixteen words at a time, runs the MD5 compression
// on each full block and emits the updated chaining value.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Beat carries
// -------  ---------  -----------------------------------------------------
// msg      in         message_word (32 bits, first byte in 7:0), start_message
// cfg      in         index (register number 0..3), data (initial chaining word)
// digest   out        digest_a, digest_b, digest_c, digest_d
//
// Each word passes through the combinational front end into the queue. The
// sixteenth word of a block starts the round engine, which loads the
// working words, runs the 64 steps (one step per cycle) and then adds into
// the chaining value; the engine takes no further words while it runs, so
// the single shared step unit sets the block rate.
// While the engine runs, the queue takes up to QUEUE_DEPTH further words.
// Reset restores the standard initial words in both the configuration and the
// chaining value and empties the queue. The result waits in an output register;
// a stalled digest channel holds the engine only when the next block finishes.
//
module md5_block_compression_top #(
    parameter int QUEUE_DEPTH = md5bc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    md5bc_in_if.sink     msg,
    md5bc_cfg_if.sink    cfg,
    md5bc_out_if.source  digest
);
    import md5bc_pkg::*;

    // Front end to queue.
    logic          push_valid;
    logic          push_ready;
    md5bc_entry_t  push_entry;

    // Queue to round engine.
    logic          pop_valid;
    logic          pop_ready;
    md5bc_entry_t  pop_entry;

    md5bc_status_t status;

    // The front end numbers the words; a start flag forces slot zero.
    md5bc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .msg        (msg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    // The queue decouples word intake from the 64-step compression.
    md5bc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    // The round engine owns the block store, the chaining value and the
    // configuration registers.
    md5bc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .cfg       (cfg),
        .digest    (digest),
        .status    (status)
    );

`ifndef NO_ASSERTIONS
    // A word that completes a block must sit in the final slot.
    a_last_slot : assert property (@(posedge clk) disable iff (!rst_n)
        push_valid && push_entry.last |-> push_entry.index == LAST_WORD)
        else $error("block-complete word not in the final slot");

    // A start word always opens a fresh block.
    a_start_slot : assert property (@(posedge clk) disable iff (!rst_n)
        push_valid && push_entry.start |-> push_entry.index == '0)
        else $error("start word not placed in slot zero");

    // The final step hands over to the chaining update.
    a_step_end : assert property (@(posedge clk) disable iff (!rst_n)
        status.state == BACK_STEP && status.step == LAST_STEP |=> status.state == BACK_FINISH)
        else $error("round engine did not finish after the last step");

    // A new digest only appears out of the chaining update.
    a_digest_source : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(digest.valid) |-> $past(status.state == BACK_FINISH))
        else $error("digest raised outside the chaining update");
`endif
endmodule

/* test/md5_block_compression_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 block compression checker
// Watches the message, configuration and digest channels of the block. It
// keeps its own copy of the chaining state and predicts one digest per
// full block. Every digest beat is compared against the oldest prediction.
// ----------------------------------------------------------------------------
module md5_block_compression_checker (
    input  logic  clk,
    input  logic  rst_n,
    md5bc_in_if   msg,
    md5bc_cfg_if  cfg,
    md5bc_out_if  digest,
    output int    errors,
    output int    pending,
    output int    checked
);
    import md5bc_pkg::*;

    typedef struct packed {
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] d;
    } chain_t;

    // Additive constants of the 64 steps, floor(abs(sin(i + 1)) * 2**32).
    localparam logic [31:0] STEP_ADD [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Left rotation per round (row) and per step within a group of four.
    localparam int unsigned STEP_ROT [16] = '{
        7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
    };

    chain_t            init_value;
    chain_t            chain;
    logic [WORD_W-1:0] msg_block [16];
    logic [IDX_W-1:0]  fill;
    chain_t            due_digests [$];
    int                mistakes;
    int                seen;

    function automatic logic [31:0] rol32(input logic [31:0] x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // The 64 steps over the buffered block, then the feed-forward addition.
    function automatic chain_t run_rounds(input chain_t h);
        logic [31:0] wa;
        logic [31:0] wb;
        logic [31:0] wc;
        logic [31:0] wd;
        logic [31:0] mix;
        logic [31:0] sum;
        int          pick;
        wa = h.a;
        wb = h.b;
        wc = h.c;
        wd = h.d;
        for (int i = 0; i < 64; i++)
        begin
            case (i / 16)
                0:
                begin
                    mix  = (wb & wc) | (~wb & wd);
                    pick = i;
                end
                1:
                begin
                    mix  = (wb & wd) | (wc & ~wd);
                    pick = 5 * i + 1;
                end
                2:
                begin
                    mix  = wb ^ wc ^ wd;
                    pick = 3 * i + 5;
                end
                default:
                begin
                    mix  = wc ^ (wb | ~wd);
                    pick = 7 * i;
                end
            endcase
            sum = wa + mix + STEP_ADD[i] + msg_block[pick % 16];
            sum = wb + rol32(sum, STEP_ROT[(i / 16) * 4 + i % 4]);
            wa  = wd;
            wd  = wc;
            wc  = wb;
            wb  = sum;
        end
        return '{a: h.a + wa, b: h.b + wb, c: h.c + wc, d: h.d + wd};
    endfunction

    // A start beat reloads the chain and restarts the block, discarding any
    // partial one; the sixteenth word of a block yields one digest.
    task automatic absorb_word(input logic [WORD_W-1:0] w, input logic start);
        if (start)
        begin
            chain = init_value;
            fill  = '0;
        end
        msg_block[fill] = w;
        fill = fill + 1'b1;
        if (fill == '0)
        begin
            chain = run_rounds(chain);
            due_digests.push_back(chain);
        end
    endtask

    function automatic int word_differs(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want === got)
            return 0;
        $display("%0t: digest_%s mismatch, expected %08h, actual %08h", $time, name, want, got);
        return 1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        chain_t want;
        chain_t got;
        int     bad;
        if (!rst_n)
        begin
            init_value = '{a: IV_A, b: IV_B, c: IV_C, d: IV_D};
            chain      = init_value;
            fill       = '0;
            due_digests.delete();
            mistakes   = 0;
            seen       = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_INIT_A: init_value.a = cfg.data;
                    CFG_INIT_B: init_value.b = cfg.data;
                    CFG_INIT_C: init_value.c = cfg.data;
                    CFG_INIT_D: init_value.d = cfg.data;
                    default: ;
                endcase
            end
            if (msg.valid && msg.ready)
                absorb_word(msg.message_word, msg.start_message);
            if (digest.valid && digest.ready)
            begin
                got = '{a: digest.digest_a, b: digest.digest_b,
                        c: digest.digest_c, d: digest.digest_d};
                if (due_digests.size() == 0)
                begin
                    $display("%0t: digest beat with none expected, actual %08h %08h %08h %08h",
                             $time, got.a, got.b, got.c, got.d);
                    mistakes++;
                end
                else
                begin
                    want = due_digests.pop_front();
                    bad  = word_differs("a", want.a, got.a) + word_differs("b", want.b, got.b)
                         + word_differs("c", want.c, got.c) + word_differs("d", want.d, got.d);
                    if (bad != 0)
                        mistakes++;
                    seen++;
                end
            end
        end
        errors  <= mistakes;
        pending <= due_digests.size();
        checked <= seen;
    end

endmodule

/* test/md5_block_compression_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 block compression testbench
// Streams padded message words into the block under several initial chaining
// settings and lets a checker compare every digest with its own prediction.
// ----------------------------------------------------------------------------
module md5_block_compression_top_tb;
    import md5bc_pkg::*;

    // Rough words per setting in the random part; five settings in all.
    localparam int PHASE_WORDS = 70;
    // Cycles allowed after the last digest for words still inside the block.
    localparam int SETTLE_CYCLES = 120;

    logic clk;
    logic rst_n;

    md5bc_in_if  msg_ch ();
    md5bc_cfg_if cfg_ch ();
    md5bc_out_if dig_ch ();

    int fail_count;
    int due_count;
    int digest_count;

    int words_sent;
    int reg_writes;
    int settings_used;
    // Percentage chance of a gap before a message beat; changes per message.
    int gap_pct;
    // Cleared for the last part of the run, where neither side idles.
    bit idle_en;

    md5_block_compression_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg_ch),
        .cfg    (cfg_ch),
        .digest (dig_ch)
    );

    md5_block_compression_checker chk (
        .clk     (clk),
        .rst_n   (rst_n),
        .msg     (msg_ch),
        .cfg     (cfg_ch),
        .digest  (dig_ch),
        .errors  (fail_count),
        .pending (due_count),
        .checked (digest_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard limit: well beyond the slowest legal run, even with every gap and
    // stall at its longest.
    initial
    begin
        #2_000_000;
        $display("FAIL md5_block_compression_top");
        $finish;
    end

    // The digest side stalls in bursts of random length. The chance per
    // cycle is modest, so long ready stretches occur as well, and because
    // digests are rare the stalls land on every phase of the engine.
    initial
    begin
        dig_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (idle_en && $urandom_range(0, 5) == 0)
            begin
                dig_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge clk);
            end
            dig_ch.ready <= 1'b1;
        end
    end

    // Mostly random words, with runs of the all-zero and all-one extremes and
    // single set or cleared bits mixed in.
    function automatic logic [WORD_W-1:0] pick_word(input int mode);
        logic [WORD_W-1:0] onehot;
        onehot = 32'h1 << $urandom_range(0, 31);
        case (mode)
            3:       return '0;
            4:       return '1;
            5:
            begin
                case ($urandom_range(0, 4))
                    0:       return '0;
                    1:       return '1;
                    2:       return onehot;
                    3:       return ~onehot;
                    default: return $urandom;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat.
    // valid stays high between back-to-back beats, and is only lowered for a
    // gap, in a time step of its own.
    task automatic push_word(input logic [WORD_W-1:0] w, input logic start);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            msg_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        msg_ch.valid         <= 1'b1;
        msg_ch.message_word  <= w;
        msg_ch.start_message <= start;
        @(posedge clk);
        while (!msg_ch.ready)
            @(posedge clk);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [WORD_W-1:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        reg_writes++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic write_init(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b,
                              input logic [WORD_W-1:0] c, input logic [WORD_W-1:0] d);
        write_reg(CFG_INIT_A, a);
        write_reg(CFG_INIT_B, b);
        write_reg(CFG_INIT_C, c);
        write_reg(CFG_INIT_D, d);
        settings_used++;
        @(negedge clk);
    endtask

    // Lower valid, let every predicted digest arrive, then give the block
    // time to take in any trailing words of a partial block, which produce
    // no digest, before the configuration is touched again.
    task automatic settle();
        msg_ch.valid <= 1'b0;
        @(posedge clk);
        while (due_count != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // Random traffic for one setting. Most of it is well-formed messages of
    // one to three blocks; the rest is cut-off messages (so the next start
    // lands mid-block), messages one word short of a block (so the next start
    // lands on what would be the sixteenth word) and loose words with a start
    // flag now and then.
    task automatic run_random(input int quota);
        int target;
        int kind;
        int mode;
        int len;
        target = words_sent + quota;
        while (words_sent < target)
        begin
            kind    = $urandom_range(0, 9);
            mode    = $urandom_range(0, 5);
            gap_pct = (!idle_en || $urandom_range(0, 3) == 0) ? 0 : 30;
            case (kind)
                7:       len = $urandom_range(1, 14);
                8:       len = 15;
                9:       len = $urandom_range(1, 20);
                default: len = 16 * $urandom_range(1, 3);
            endcase
            for (int k = 0; k < len; k++)
            begin
                if (kind == 9)
                    push_word(pick_word(mode), $urandom_range(0, 7) == 0);
                else
                    push_word(pick_word(mode), k == 0);
            end
        end
    endtask

    initial
    begin
        msg_ch.valid         = 1'b0;
        msg_ch.message_word  = '0;
        msg_ch.start_message = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.index         = CFG_INIT_A;
        cfg_ch.data          = '0;
        words_sent           = 0;
        reg_writes           = 0;
        settings_used        = 1;
        gap_pct              = 0;
        idle_en              = 1'b1;

        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part, on the reset configuration.
        // A message without any start flag runs on the reset chaining value:
        // here the padded empty message, whose digest is the well-known one.
        gap_pct = 30;
        for (int k = 0; k < 16; k++)
            push_word(k == 0 ? 32'h0000_0080 : 32'h0, 1'b0);
        // A start, three more all-one words, then a start in mid-block that
        // throws the partial block away.
        for (int k = 0; k < 5; k++)
            push_word('1, k == 0 || k == 4);
        settle();

        // Random part over several settings: both extremes, two random ones
        // and finally the standard words written back.
        write_init('0, '0, '0, '0);
        run_random(PHASE_WORDS);
        settle();
        write_init('1, '1, '1, '1);
        run_random(PHASE_WORDS);
        settle();
        write_init($urandom, $urandom, $urandom, $urandom);
        run_random(PHASE_WORDS);
        settle();
        write_init($urandom, '1, '0, $urandom);
        run_random(PHASE_WORDS);
        settle();

        // Last part: full throughput, no gaps and no stalls.
        idle_en = 1'b0;
        write_init(IV_A, IV_B, IV_C, IV_D);
        run_random(PHASE_WORDS);
        settle();

        $display("Run covered %0d message words under %0d chaining settings (%0d register writes),",
                 words_sent, settings_used, reg_writes);
        $display("with %0d digests compared field by field against the prediction.",
                 digest_count);
        if (fail_count == 0)
            $display("PASS md5_block_compression_top");
        else
            $display("FAIL md5_block_compression_top");
        $finish;
    end

endmodule

/* files.f */
sv/md5bc_pkg.sv
sv/md5bc_in_if.sv
sv/md5bc_out_if.sv
sv/md5bc_cfg_if.sv
sv/md5bc_front.sv
sv/md5bc_queue.sv
sv/md5bc_back.sv
sv/md5_block_compression_top.sv
test/md5_block_compression_checker.sv
test/md5_block_compression_top_tb.sv
